### src/cbft_pkg.sv
// ----------------------------------------------------------------------------
// cbft_pkg
// widths and constants shared by the foot trajectory sampler and its
// per-coordinate datapath
// ----------------------------------------------------------------------------
package cbft_pkg;

  localparam int MAX_SAMPLES     = 64;
  localparam int COORD_FRAC_BITS = 6;   // q10.6 millimetres, scale free datapath

  localparam int COORD_W = 16;
  localparam int LEG_W   = 3;
  localparam int CNT_W   = $clog2(MAX_SAMPLES);
  localparam int SQ_W    = 2 * CNT_W;
  localparam int CUBE_W  = 3 * CNT_W;
  localparam int T3_W    = CNT_W + 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W + CUBE_W;
  localparam int NUM_W   = MAG_W + 2;
  localparam int QUO_W   = COORD_W;

  // registers from coordinate datapath input to its registered output
  localparam int COORD_LAT = QUO_W + 4;

  localparam int S_TDATA_W = ((LEG_W + 6 * COORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((LEG_W + CNT_W + 3 * COORD_W + 7) / 8) * 8;

  localparam int STEP_COUNT_RST = 20;
  localparam int NSQ_RST        = STEP_COUNT_RST * STEP_COUNT_RST;
  localparam int NCUBE_RST      = NSQ_RST * STEP_COUNT_RST;

  localparam int  APB_ADDR_W        = 3;
  localparam int  APB_DATA_W        = 32;
  localparam logic REG_IDX_STEP_COUNT = 1'b0;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};

endpackage

### src/cbft_coord.sv
// ----------------------------------------------------------------------------
// cbft_coord
// one coordinate of a curve sample: base*cube + weight*diff, rounded
// division by cube through a one-bit-per-stage restoring divider, saturate
// ----------------------------------------------------------------------------
module cbft_coord (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic        [cbft_pkg::CUBE_W-1:0]   weight_i,
  input  logic        [cbft_pkg::CUBE_W-1:0]   cube_i,
  input  logic signed [cbft_pkg::COORD_W-1:0]  base_i,
  input  logic signed [cbft_pkg::DIFF_W-1:0]   diff_i,
  output logic signed [cbft_pkg::COORD_W-1:0]  pos_o
);

  logic signed [cbft_pkg::CUBE_W:0]    wt_s;
  logic signed [cbft_pkg::CUBE_W:0]    cube_s;
  logic signed [cbft_pkg::NUM_W-1:0]   prod_q;
  logic signed [cbft_pkg::NUM_W-1:0]   bc_q;
  logic signed [cbft_pkg::NUM_W-1:0]   num_q;
  logic        [cbft_pkg::NUM_W-1:0]   half;
  logic        [cbft_pkg::NUM_W-1:0]   mag_full;
  logic        [cbft_pkg::MAG_W-1:0]   mag_q;
  logic                                sgn_q;

  logic [cbft_pkg::MAG_W-1:0] rem_in [cbft_pkg::QUO_W];
  logic [cbft_pkg::QUO_W-1:0] quo_in [cbft_pkg::QUO_W];
  logic                       neg_in [cbft_pkg::QUO_W];
  logic [cbft_pkg::MAG_W-1:0] dsr    [cbft_pkg::QUO_W];
  logic [cbft_pkg::MAG_W-1:0] rem_d  [cbft_pkg::QUO_W];
  logic [cbft_pkg::QUO_W-1:0] quo_d  [cbft_pkg::QUO_W];
  logic [cbft_pkg::MAG_W-1:0] rem_q  [cbft_pkg::QUO_W];
  logic [cbft_pkg::QUO_W-1:0] quo_q  [cbft_pkg::QUO_W];
  logic                       neg_q  [cbft_pkg::QUO_W];

  logic [cbft_pkg::QUO_W-1:0]          quo_fin;
  logic signed [cbft_pkg::COORD_W-1:0] pos_d;
  logic signed [cbft_pkg::COORD_W-1:0] pos_q;

  assign wt_s   = signed'({1'b0, weight_i});
  assign cube_s = signed'({1'b0, cube_i});

  // rounding to nearest, ties away from zero: divide |num| + floor(cube/2)
  assign half     = cbft_pkg::NUM_W'(cube_i >> 1);
  assign mag_full = num_q[cbft_pkg::NUM_W-1] ? (half - $unsigned(num_q))
                                             : ($unsigned(num_q) + half);

  always_comb begin
    rem_in[0] = mag_q;
    quo_in[0] = '0;
    neg_in[0] = sgn_q;
    for (int k = 1; k < cbft_pkg::QUO_W; k++) begin
      rem_in[k] = rem_q[k-1];
      quo_in[k] = quo_q[k-1];
      neg_in[k] = neg_q[k-1];
    end
    for (int k = 0; k < cbft_pkg::QUO_W; k++) begin
      dsr[k]   = cbft_pkg::MAG_W'(cube_i) << (cbft_pkg::QUO_W - 1 - k);
      rem_d[k] = rem_in[k];
      quo_d[k] = quo_in[k];
      if (rem_in[k] >= dsr[k]) begin
        rem_d[k] = rem_in[k] - dsr[k];
        quo_d[k][cbft_pkg::QUO_W-1-k] = 1'b1;
      end
    end
  end

  // quotient is at most 2^15, only the positive side can overflow
  assign quo_fin = quo_q[cbft_pkg::QUO_W-1];
  always_comb begin
    if (neg_q[cbft_pkg::QUO_W-1]) begin
      pos_d = signed'(cbft_pkg::COORD_W'(0) - quo_fin);
    end else if (quo_fin[cbft_pkg::QUO_W-1]) begin
      pos_d = signed'(cbft_pkg::COORD_MAX);
    end else begin
      pos_d = signed'(quo_fin);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= wt_s * diff_i;
      bc_q   <= cube_s * base_i;
      num_q  <= prod_q + bc_q;
      mag_q  <= mag_full[cbft_pkg::MAG_W-1:0];
      sgn_q  <= num_q[cbft_pkg::NUM_W-1];
      for (int k = 0; k < cbft_pkg::QUO_W; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        neg_q[k] <= neg_in[k];
      end
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

### src/cubic_bezier_foot_trajectory.sv
// ----------------------------------------------------------------------------
// cubic_bezier_foot_trajectory
// samples a cubic bezier foot path at N+1 evenly spaced points per request
// ----------------------------------------------------------------------------
// Each input beat names a leg, a start point, an end point and a mode and
// expands into N+1 output beats, the curve at t = i/N for i = 0..N, where N
// is the step_count register (0 reads as 1). Straight mode uses control
// points start, start, end, end; step mode lifts the two middle z points so
// the foot passes end_z_or_peak at t = 1/2 and lands back at start z. Points
// are signed q10.6, rounded to nearest (ties away from zero) and saturated;
// the last sample carries tlast. One sample leaves per cycle while the
// output is not stalled; a request holds the input until its last sample
// issues, and the next one is taken as that one issues. A sample passes
// the request holding register, three stages that build the bernstein
// weights, a multiply, an add, a rounding stage, a 16-stage restoring
// divider (one quotient bit per stage) and the output register. A downstream
// stall freezes the whole pipe. step_count may only be written while no
// samples are in flight; N^2 and then N^3 are registered from it.
// ----------------------------------------------------------------------------
module cubic_bezier_foot_trajectory (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input request
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // leg, start_x, start_y, start_z, end_x, end_y, end_z_or_peak, zero pad
  input  logic [cbft_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  // mode
  input  logic                                  s_axis_tuser,
  // output samples
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // leg_tag, sample_index, pos_x, pos_y, pos_z, zero pad
  output logic [cbft_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  output logic                                  m_axis_tlast,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cbft_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [cbft_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [cbft_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int CW = cbft_pkg::COORD_W;
  localparam int DW = cbft_pkg::DIFF_W;
  localparam int NW = cbft_pkg::CNT_W;
  localparam int LW = cbft_pkg::LEG_W;
  localparam int LAT = cbft_pkg::COORD_LAT;

  typedef struct packed {
    logic          last;
    logic [NW-1:0] idx;
    logic [LW-1:0] leg;
  } meta_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } geom_t;

  // --------------------------------------------------------------------------
  // step_count register and the derived divisor N^3
  // --------------------------------------------------------------------------
  logic [NW-1:0]                 n_q;
  logic [NW-1:0]                 n_eff;
  logic [cbft_pkg::SQ_W-1:0]     nsq_q;
  logic [cbft_pkg::CUBE_W-1:0]   ncube_q;
  logic                          cfg_wr;
  logic                          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == cbft_pkg::REG_IDX_STEP_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? cbft_pkg::APB_DATA_W'(n_q) : '0;

  // zero step count behaves as a single interval
  assign n_eff = (n_q == '0) ? NW'(1) : n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= NW'(cbft_pkg::STEP_COUNT_RST);
      nsq_q   <= cbft_pkg::SQ_W'(cbft_pkg::NSQ_RST);
      ncube_q <= cbft_pkg::CUBE_W'(cbft_pkg::NCUBE_RST);
    end else begin
      if (cfg_wr) begin
        n_q <= pwdata[NW-1:0];
      end
      nsq_q   <= n_eff * n_eff;
      ncube_q <= cbft_pkg::CUBE_W'(nsq_q * n_eff);
    end
  end

  // --------------------------------------------------------------------------
  // request holding register and sample sequencer
  // --------------------------------------------------------------------------
  logic                 adv;        // whole pipe moves when output can drain
  logic                 s_accept;
  logic                 issue;
  logic                 busy_q;
  logic [NW-1:0]        i_q;
  logic [NW-1:0]        seq_n_q;    // N latched with the request
  logic                 seq_last;

  logic                 mode_q;
  logic [LW-1:0]        leg_q;
  logic signed [CW-1:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;

  logic                 vld_q [LAT];
  meta_t                meta_q [LAT];

  assign m_axis_tvalid = vld_q[LAT-1];
  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign seq_last      = (i_q == seq_n_q);
  assign s_axis_tready = adv && (!busy_q || seq_last);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign issue         = adv && busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      i_q     <= '0;
      seq_n_q <= NW'(cbft_pkg::STEP_COUNT_RST);
    end else if (s_accept) begin
      busy_q  <= 1'b1;
      i_q     <= '0;
      seq_n_q <= n_eff;
    end else if (issue) begin
      if (seq_last) begin
        busy_q <= 1'b0;
      end else begin
        i_q <= i_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      mode_q <= s_axis_tuser;
      leg_q  <= s_axis_tdata[LW-1:0];
      sx_q   <= s_axis_tdata[LW + 0*CW +: CW];
      sy_q   <= s_axis_tdata[LW + 1*CW +: CW];
      sz_q   <= s_axis_tdata[LW + 2*CW +: CW];
      ex_q   <= s_axis_tdata[LW + 3*CW +: CW];
      ey_q   <= s_axis_tdata[LW + 4*CW +: CW];
      ez_q   <= s_axis_tdata[LW + 5*CW +: CW];
    end
  end

  // --------------------------------------------------------------------------
  // weight stages
  // x, y and straight z: value = s + B*(e-s)/N^3, B = i^2 (3N - 2i)
  // lifted z:            value = sz + 4 i u N (peak-sz)/N^3, u = N - i
  // --------------------------------------------------------------------------
  logic                          v1_q, v2_q, v3_q;
  meta_t                         meta1_q, meta2_q, meta3_q;
  geom_t                         geom1_q, geom2_q, geom3_q;
  geom_t                         geom1_d;
  logic                          mode1_q, mode2_q;
  logic [NW-1:0]                 n1_q, n2_q, i1_q, u1_q;
  logic [cbft_pkg::SQ_W-1:0]     iu2_q, ii2_q;
  logic [cbft_pkg::T3_W-1:0]     t3_2_q, t3_d;
  logic [cbft_pkg::CUBE_W-1:0]   wb_d, ws_d, wb3_q, wz3_q;

  always_comb begin
    geom1_d.sx = sx_q;
    geom1_d.sy = sy_q;
    geom1_d.sz = sz_q;
    geom1_d.dx = DW'(ex_q) - DW'(sx_q);
    geom1_d.dy = DW'(ey_q) - DW'(sy_q);
    geom1_d.dz = DW'(ez_q) - DW'(sz_q);
  end

  assign t3_d = ((cbft_pkg::T3_W'(n1_q) << 1) + cbft_pkg::T3_W'(n1_q))
              - (cbft_pkg::T3_W'(i1_q) << 1);
  assign wb_d = cbft_pkg::CUBE_W'(ii2_q * t3_2_q);
  assign ws_d = cbft_pkg::CUBE_W'(iu2_q * n2_q) << 2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta1_q <= '{last: seq_last, idx: i_q, leg: leg_q};
      geom1_q <= geom1_d;
      mode1_q <= mode_q;
      n1_q    <= seq_n_q;
      i1_q    <= i_q;
      u1_q    <= seq_n_q - i_q;

      meta2_q <= meta1_q;
      geom2_q <= geom1_q;
      mode2_q <= mode1_q;
      n2_q    <= n1_q;
      iu2_q   <= i1_q * u1_q;
      ii2_q   <= i1_q * i1_q;
      t3_2_q  <= t3_d;

      meta3_q <= meta2_q;
      geom3_q <= geom2_q;
      wb3_q   <= wb_d;
      wz3_q   <= mode2_q ? ws_d : wb_d;
    end
  end

  // --------------------------------------------------------------------------
  // per-coordinate multiply, round and divide
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] pos_x, pos_y, pos_z;

  cbft_coord u_coord_x (
    .clk_i    (clk_i),
    .en_i     (adv),
    .weight_i (wb3_q),
    .cube_i   (ncube_q),
    .base_i   (geom3_q.sx),
    .diff_i   (geom3_q.dx),
    .pos_o    (pos_x)
  );

  cbft_coord u_coord_y (
    .clk_i    (clk_i),
    .en_i     (adv),
    .weight_i (wb3_q),
    .cube_i   (ncube_q),
    .base_i   (geom3_q.sy),
    .diff_i   (geom3_q.dy),
    .pos_o    (pos_y)
  );

  cbft_coord u_coord_z (
    .clk_i    (clk_i),
    .en_i     (adv),
    .weight_i (wz3_q),
    .cube_i   (ncube_q),
    .base_i   (geom3_q.sz),
    .diff_i   (geom3_q.dz),
    .pos_o    (pos_z)
  );

  // valid bits and tags ride alongside the coordinate datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= v3_q;
      for (int k = 1; k < LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta3_q;
      for (int k = 1; k < LAT; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  assign m_axis_tlast = meta_q[LAT-1].last;
  assign m_axis_tdata = cbft_pkg::M_TDATA_W'({pos_z, pos_y, pos_x,
                                              meta_q[LAT-1].idx,
                                              meta_q[LAT-1].leg});

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (i_q <= seq_n_q))
    else $error("sample counter ran past the step count");

  a_accept_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && busy_q) |-> seq_last)
    else $error("new request taken before the last sample issued");

  a_idx_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !seq_last && !s_accept) |=> (i_q == $past(i_q) + NW'(1)))
    else $error("sample index skipped or repeated");

  a_run_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && seq_last && !s_accept) |=> !busy_q)
    else $error("sequencer stayed busy after the last sample");

endmodule
